// File: sv/lbs_pkg.sv
// Shared constants, codes and types of the letterbox bilinear scaler.
// Depends on nothing; every other file of the block but lbs_ram imports it.
package lbs_pkg;

   localparam int SRC_WIDTH_MAX    = 1024;
   localparam int SRC_HEIGHT_MAX   = 1024;
   localparam int WEIGHT_FRAC_BITS = 8;

   localparam int COORD_BITS = 12;
   localparam int SIZE_BITS  = 11;
   localparam int DST_BITS   = 12;
   localparam int PIXEL_BITS = 24;
   localparam int CH_BITS    = 8;

   localparam int COL_BITS   = $clog2(SRC_WIDTH_MAX);
   localparam int ROW_BITS   = $clog2(SRC_HEIGHT_MAX);
   localparam int IDX_BITS   = SIZE_BITS - 1;
   localparam int BANK_ABITS = COL_BITS + ROW_BITS - 2;
   localparam int BANK_DEPTH = 1 << BANK_ABITS;

   localparam int FRAC       = WEIGHT_FRAC_BITS;
   localparam int ONE        = 1 << FRAC;
   localparam int PROD_BITS  = COORD_BITS + IDX_BITS;
   localparam int NUM_BITS   = PROD_BITS + FRAC;
   localparam int RECIP_BITS = NUM_BITS + 1;
   localparam int Q_BITS     = IDX_BITS + FRAC;
   localparam int R_BITS     = COORD_BITS + 1;
   localparam int W_BITS     = FRAC + 2;
   localparam int WT_BITS    = 2 * W_BITS;
   localparam int ACC_BITS   = WT_BITS + CH_BITS + 3;

   localparam int GAIN_NUM   = 461;
   localparam int GAIN_BITS  = 9;
   localparam int GAIN_SHIFT = 2 * FRAC + 9;
   localparam int GP_BITS    = ACC_BITS + GAIN_BITS;

   localparam logic [PIXEL_BITS-1:0] COLOR_BLUE  = 24'h0000FF;
   localparam logic [PIXEL_BITS-1:0] COLOR_BLACK = 24'h000000;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   localparam logic [2:0] KIND_WRITE = 3'd0;
   localparam logic [2:0] KIND_BLUE  = 3'd1;
   localparam logic [2:0] KIND_BLACK = 3'd2;
   localparam logic [2:0] KIND_RAW   = 3'd3;
   localparam logic [2:0] KIND_BLEND = 3'd4;

   localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
   localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

   typedef struct packed {
      logic [COORD_BITS-1:0] lo;
      logic [COORD_BITS-1:0] hi;
      logic [COORD_BITS-1:0] span;
      logic [SIZE_BITS-1:0]  size;
      logic [RECIP_BITS-1:0] recip;
   } axis_geom_type;

   typedef struct packed {
      logic                  op;
      logic                  raw;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [PIXEL_BITS-1:0] pix;
   } item_type;

endpackage

// File: sv/lbs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for every bank of the frame store.
module lbs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/lbs_geom.sv
// Geometry sequencer: margins, fitted window and per-axis reciprocals,
// computed with one shared bit-serial divider. Depends on lbs_pkg.
module lbs_geom import lbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SIZE_BITS-1:0]  src_width,
   input  logic [SIZE_BITS-1:0]  src_height,
   input  logic [DST_BITS-1:0]   dst_width,
   input  logic [DST_BITS-1:0]   dst_height,
   output logic                  busy,
   output axis_geom_type         geom_x,
   output axis_geom_type         geom_y
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PROD   = 3'd1;
   localparam logic [2:0] ST_SETUP  = 3'd2;
   localparam logic [2:0] ST_MARGIN = 3'd3;
   localparam logic [2:0] ST_LOADX  = 3'd4;
   localparam logic [2:0] ST_RECX   = 3'd5;
   localparam logic [2:0] ST_LOADY  = 3'd6;
   localparam logic [2:0] ST_RECY   = 3'd7;

   localparam int DIV_BITS = RECIP_BITS;
   localparam int DEN_BITS = COORD_BITS;
   localparam int CNT_BITS = $clog2(DIV_BITS + 1);
   localparam int AB_BITS  = SIZE_BITS + DST_BITS;

   logic [2:0]            state_ff;
   logic [AB_BITS-1:0]    a_ff, b_ff;
   logic                  wide_ff;
   logic [DEN_BITS-1:0]   rem_ff, den_ff;
   logic [DIV_BITS-1:0]   quo_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   axis_geom_type         gx_ff, gy_ff;

   logic [SIZE_BITS-1:0]  w, h;
   logic [DST_BITS-1:0]   dw, dh;
   logic [DEN_BITS:0]     trial;
   logic                  ge;
   logic [DEN_BITS-1:0]   rem_in;
   logic [DIV_BITS-1:0]   quo_in;
   logic                  done;
   logic [COORD_BITS-1:0] mx, my, x1, y1;

   always_comb begin
      w = src_width;
      if (src_width < SIZE_BITS'(2)) w = SIZE_BITS'(2);
      else if (src_width > SIZE_BITS'(SRC_WIDTH_MAX)) w = SIZE_BITS'(SRC_WIDTH_MAX);
      h = src_height;
      if (src_height < SIZE_BITS'(2)) h = SIZE_BITS'(2);
      else if (src_height > SIZE_BITS'(SRC_HEIGHT_MAX)) h = SIZE_BITS'(SRC_HEIGHT_MAX);
      dw = (dst_width == '0) ? DST_BITS'(1) : dst_width;
      dh = (dst_height == '0) ? DST_BITS'(1) : dst_height;
   end

   // One restoring-division step per cycle, dividend shifted in MSB first.
   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_BITS-1]};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? DEN_BITS'(trial - {1'b0, den_ff}) : trial[DEN_BITS-1:0];
      quo_in = {quo_ff[DIV_BITS-2:0], ge};
      done   = cnt_ff == CNT_BITS'(DIV_BITS);
   end

   always_comb begin
      mx = wide_ff ? '0 : quo_ff[COORD_BITS-1:0];
      my = wide_ff ? quo_ff[COORD_BITS-1:0] : '0;
      x1 = mx >> 1;
      y1 = my >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PROD;
      end else if (start) begin
         state_ff <= ST_PROD;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               state_ff <= ST_IDLE;
            end
            ST_PROD: begin
               state_ff <= ST_SETUP;
            end
            ST_SETUP: begin
               state_ff <= ST_MARGIN;
            end
            ST_MARGIN: begin
               if (done) state_ff <= ST_LOADX;
            end
            ST_LOADX: begin
               state_ff <= ST_RECX;
            end
            ST_RECX: begin
               if (done) state_ff <= ST_LOADY;
            end
            ST_LOADY: begin
               state_ff <= ST_RECY;
            end
            ST_RECY: begin
               if (done) state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_PROD: begin
            a_ff <= AB_BITS'(w) * AB_BITS'(dh);
            b_ff <= AB_BITS'(dw) * AB_BITS'(h);
         end
         ST_SETUP: begin
            wide_ff    <= a_ff > b_ff;
            rem_ff     <= '0;
            quo_ff     <= (a_ff > b_ff) ? DIV_BITS'(a_ff - b_ff) : DIV_BITS'(b_ff - a_ff);
            den_ff     <= (a_ff > b_ff) ? DEN_BITS'(w) : DEN_BITS'(h);
            cnt_ff     <= '0;
            gx_ff.size <= w;
            gy_ff.size <= h;
         end
         ST_MARGIN, ST_RECX, ST_RECY: begin
            if (!done) begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               cnt_ff <= cnt_ff + CNT_BITS'(1);
            end else if (state_ff == ST_MARGIN) begin
               gx_ff.lo   <= x1;
               gx_ff.hi   <= dw - x1;
               gx_ff.span <= dw - {x1[COORD_BITS-2:0], 1'b0};
               gy_ff.lo   <= y1;
               gy_ff.hi   <= dh - y1;
               gy_ff.span <= dh - {y1[COORD_BITS-2:0], 1'b0};
            end else if (state_ff == ST_RECX) begin
               gx_ff.recip <= quo_ff;
            end else begin
               gy_ff.recip <= quo_ff;
            end
         end
         ST_LOADX, ST_LOADY: begin
            rem_ff <= '0;
            quo_ff <= {1'b1, NUM_BITS'(0)};
            den_ff <= (state_ff == ST_LOADX) ? gx_ff.span : gy_ff.span;
            cnt_ff <= '0;
         end
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
   end

   assign busy   = state_ff != ST_IDLE;
   assign geom_x = gx_ff;
   assign geom_y = gy_ff;

endmodule

// File: sv/lbs_axis.sv
// Five-stage coordinate mapper for one axis: window test, source position by
// reciprocal multiply with one correction, index clamp and weights. Uses lbs_pkg.
module lbs_axis import lbs_pkg::*; (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [COORD_BITS-1:0]       coord,
   input  axis_geom_type               geom,
   output logic [IDX_BITS-1:0]         idx,
   output logic signed [W_BITS-1:0]    w0,
   output logic signed [W_BITS-1:0]    w1,
   output logic                        outside
);

   localparam int PW = NUM_BITS + RECIP_BITS;

   logic [COORD_BITS-1:0]     off1_ff;
   logic [NUM_BITS-1:0]       n2_ff, n3_ff;
   logic [Q_BITS-1:0]         q3_ff, q4_ff;
   logic [R_BITS-1:0]         r4_ff;
   logic [4:0]                out_ff;
   logic [IDX_BITS-1:0]       idx_ff;
   logic signed [W_BITS-1:0]  w0_ff, w1_ff;

   logic [PROD_BITS-1:0]      prod_in;
   logic [PW-1:0]             nr_in;
   logic [NUM_BITS-1:0]       qs_in;
   logic [Q_BITS-1:0]         u_in;
   logic [IDX_BITS-1:0]       lim, idx_in;
   logic [FRAC:0]             d;
   logic signed [W_BITS-1:0]  e, w0_in, w1_in;

   always_comb begin
      prod_in = PROD_BITS'(off1_ff) * PROD_BITS'(geom.size);
      nr_in   = PW'(n2_ff) * PW'(geom.recip);
      qs_in   = NUM_BITS'(q3_ff) * NUM_BITS'(geom.span);
   end

   // The estimate is at most one low, so a single compare fixes it.
   always_comb begin
      u_in = q4_ff + Q_BITS'(r4_ff >= R_BITS'(geom.span));
      lim  = IDX_BITS'(geom.size - SIZE_BITS'(2));
      if (u_in[Q_BITS-1:FRAC] > lim) begin
         idx_in = lim;
         d      = (FRAC+1)'(u_in - {lim, FRAC'(0)});
      end else begin
         idx_in = u_in[Q_BITS-1:FRAC];
         d      = {1'b0, u_in[FRAC-1:0]};
      end
      e     = $signed(W_BITS'(d)) - W_BITS'(ONE);
      if (e < 0) e = -e;
      w0_in = W_BITS'(ONE) - $signed(W_BITS'(d));
      w1_in = W_BITS'(ONE) - e;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         off1_ff <= coord - geom.lo;
         out_ff  <= {out_ff[3:0], (coord < geom.lo) || (coord >= geom.hi)};
         n2_ff   <= {prod_in, FRAC'(0)};
         n3_ff   <= n2_ff;
         q3_ff   <= nr_in[NUM_BITS +: Q_BITS];
         q4_ff   <= q3_ff;
         r4_ff   <= R_BITS'(n3_ff - qs_in);
         idx_ff  <= idx_in;
         w0_ff   <= w0_in;
         w1_ff   <= w1_in;
      end
   end

   assign idx     = idx_ff;
   assign w0      = w0_ff;
   assign w1      = w1_ff;
   assign outside = out_ff[4];

endmodule

// File: sv/letterbox_bilinear_scaler_top.sv
// Top level of the letterbox bilinear scaler: register port, pipeline control,
// four-bank frame store and the blend. Depends on lbs_pkg, lbs_geom, lbs_axis, lbs_ram.
//
// Usage:
// The req channel carries writes (op 0) of one source pixel and requests
// (op 1) of one destination pixel; only requests produce a rsp transaction.
// A request goes through the mapper stages, bank read, blend and rsp register;
// the pipeline takes one transaction per cycle while not held. Writes and
// requests keep their order, so a request sees every earlier write.
// The frame store is split into four banks by column and row parity, so the
// four neighbours of a request come out of one read of each bank per cycle.
// After reset, and after every register write, the geometry unit works out
// the margins and the two reciprocals (one shared divider, one quotient bit
// per cycle); req_ready is low during that time.
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline holds and req_ready drops in the same cycle.
// Reset restores the default register values; the frame store is not cleared.
module letterbox_bilinear_scaler_top import lbs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [COORD_BITS-1:0]  req_x,
   input  logic [COORD_BITS-1:0]  req_y,
   input  logic [PIXEL_BITS-1:0]  req_pixel_in,
   input  logic                   req_raw_copy,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIXEL_BITS-1:0]  rsp_pixel_out,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic [SIZE_BITS-1:0]  src_width_ff, src_height_ff;
   logic [DST_BITS-1:0]   dst_width_ff, dst_height_ff;
   logic                  csr_write;
   logic                  busy;
   axis_geom_type         geom_x, geom_y;

   logic                  adv;
   logic [4:0]            vld_ff;
   item_type              pipe_ff [5];
   item_type              item_in;

   logic [IDX_BITS-1:0]       x0, y0;
   logic signed [W_BITS-1:0]  wx0, wx1, wy0, wy1;
   logic                      outx, outy;

   logic [2:0]            kind5;
   logic                  in_store;
   logic                  bank_we [4];
   logic                  bank_re [4];
   logic [BANK_ABITS-1:0] bank_raddr [4];
   logic [BANK_ABITS-1:0] bank_waddr;
   logic [PIXEL_BITS-1:0] bank_rdata [4];

   logic                      vld6_ff, vld7_ff;
   logic [2:0]                kind6_ff, kind7_ff;
   logic [1:0]                par6_ff;
   logic signed [WT_BITS-1:0] wt6_ff [4];
   logic signed [WT_BITS-1:0] wt_in [4];
   logic signed [ACC_BITS-1:0] acc7_ff [3];
   logic signed [ACC_BITS-1:0] acc_in [3];
   logic [PIXEL_BITS-1:0]     raw7_ff;
   logic [PIXEL_BITS-1:0]     nb [4];

   logic                  rsp_valid_ff;
   logic [PIXEL_BITS-1:0] rsp_pixel_ff;
   logic [PIXEL_BITS-1:0] pixel_in;

   // Register port.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SIZE_BITS'(640);
         src_height_ff <= SIZE_BITS'(480);
         dst_width_ff  <= DST_BITS'(800);
         dst_height_ff <= DST_BITS'(800);
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_SRC_WIDTH:  src_width_ff  <= csr_pwdata[SIZE_BITS-1:0];
            REG_SRC_HEIGHT: src_height_ff <= csr_pwdata[SIZE_BITS-1:0];
            REG_DST_WIDTH:  dst_width_ff  <= csr_pwdata[DST_BITS-1:0];
            REG_DST_HEIGHT: dst_height_ff <= csr_pwdata[DST_BITS-1:0];
            default:        src_width_ff  <= src_width_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_SRC_WIDTH:  csr_prdata = 32'(src_width_ff);
         REG_SRC_HEIGHT: csr_prdata = 32'(src_height_ff);
         REG_DST_WIDTH:  csr_prdata = 32'(dst_width_ff);
         REG_DST_HEIGHT: csr_prdata = 32'(dst_height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   lbs_geom u_geom (
      .clock      (clock),
      .reset      (reset),
      .start      (csr_write),
      .src_width  (src_width_ff),
      .src_height (src_height_ff),
      .dst_width  (dst_width_ff),
      .dst_height (dst_height_ff),
      .busy       (busy),
      .geom_x     (geom_x),
      .geom_y     (geom_y)
   );

   // The whole pipeline moves together whenever the output register can take data.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !busy;

   always_comb begin
      item_in.op  = req_op;
      item_in.raw = req_raw_copy;
      item_in.x   = req_x;
      item_in.y   = req_y;
      item_in.pix = req_pixel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
      end else if (adv) begin
         vld_ff  <= {vld_ff[3:0], req_valid && !busy};
         vld6_ff <= vld_ff[4];
         vld7_ff <= vld6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff[0] <= item_in;
         for (int k = 1; k < 5; k++) begin
            pipe_ff[k] <= pipe_ff[k-1];
         end
      end
   end

   lbs_axis u_axis_x (
      .clock   (clock),
      .adv     (adv),
      .coord   (req_x),
      .geom    (geom_x),
      .idx     (x0),
      .w0      (wx0),
      .w1      (wx1),
      .outside (outx)
   );

   lbs_axis u_axis_y (
      .clock   (clock),
      .adv     (adv),
      .coord   (req_y),
      .geom    (geom_y),
      .idx     (y0),
      .w0      (wy0),
      .w1      (wy1),
      .outside (outy)
   );

   // Classify the transaction now that both axes are mapped.
   always_comb begin
      if (pipe_ff[4].op == OP_WRITE) kind5 = KIND_WRITE;
      else if (outx) kind5 = KIND_BLUE;
      else if (outy) kind5 = KIND_BLACK;
      else if (pipe_ff[4].raw) kind5 = KIND_RAW;
      else kind5 = KIND_BLEND;
      in_store = (pipe_ff[4].x[COORD_BITS-1:COL_BITS] == '0)
              && (pipe_ff[4].y[COORD_BITS-1:ROW_BITS] == '0);
   end

   // Bank b holds column parity b[0] and row parity b[1]; each neighbour
   // lands in a different bank.
   always_comb begin
      logic [1:0]          sel;
      logic [IDX_BITS-1:0] col, row;
      bank_waddr = {pipe_ff[4].y[ROW_BITS-1:1], pipe_ff[4].x[COL_BITS-1:1]};
      for (int b = 0; b < 4; b++) begin
         sel = 2'(b);
         col = (x0[0] == sel[0]) ? x0 : x0 + IDX_BITS'(1);
         row = (y0[0] == sel[1]) ? y0 : y0 + IDX_BITS'(1);
         bank_raddr[b] = {row[ROW_BITS-1:1], col[COL_BITS-1:1]};
         bank_re[b]    = adv && vld_ff[4] && (kind5 == KIND_RAW || kind5 == KIND_BLEND);
         bank_we[b]    = adv && vld_ff[4] && (kind5 == KIND_WRITE) && in_store
                      && (pipe_ff[4].x[0] == sel[0]) && (pipe_ff[4].y[0] == sel[1]);
      end
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      lbs_ram #(
         .WIDTH (PIXEL_BITS),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock (clock),
         .we    (bank_we[b]),
         .waddr (bank_waddr),
         .wdata (pipe_ff[4].pix),
         .re    (bank_re[b]),
         .raddr (bank_raddr[b]),
         .rdata (bank_rdata[b])
      );
   end

   always_comb begin
      wt_in[0] = WT_BITS'(wy0) * WT_BITS'(wx0);
      wt_in[1] = WT_BITS'(wy0) * WT_BITS'(wx1);
      wt_in[2] = WT_BITS'(wy1) * WT_BITS'(wx0);
      wt_in[3] = WT_BITS'(wy1) * WT_BITS'(wx1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind6_ff <= kind5;
         par6_ff  <= {y0[0], x0[0]};
         for (int k = 0; k < 4; k++) begin
            wt6_ff[k] <= wt_in[k];
         end
      end
   end

   // Neighbour k flips the column parity with k[0] and the row parity with k[1].
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         nb[k] = bank_rdata[par6_ff ^ 2'(k)];
      end
      for (int c = 0; c < 3; c++) begin
         acc_in[c] = '0;
         for (int k = 0; k < 4; k++) begin
            acc_in[c] = acc_in[c] + ACC_BITS'(wt6_ff[k])
                      * $signed(ACC_BITS'(nb[k][c*CH_BITS +: CH_BITS]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind7_ff <= kind6_ff;
         raw7_ff  <= nb[0];
         for (int c = 0; c < 3; c++) begin
            acc7_ff[c] <= acc_in[c];
         end
      end
   end

   // Gain of 461/512, truncation and saturation per channel.
   always_comb begin
      logic [GP_BITS-1:0] gp;
      for (int c = 0; c < 3; c++) begin
         gp = GP_BITS'($unsigned(acc7_ff[c])) * GP_BITS'(GAIN_NUM);
         gp = gp >> GAIN_SHIFT;
         if (acc7_ff[c] <= 0) begin
            pixel_in[c*CH_BITS +: CH_BITS] = '0;
         end else if (gp > GP_BITS'(255)) begin
            pixel_in[c*CH_BITS +: CH_BITS] = 8'hFF;
         end else begin
            pixel_in[c*CH_BITS +: CH_BITS] = gp[CH_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld7_ff && (kind7_ff != KIND_WRITE);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         case (kind7_ff)
            KIND_BLUE:  rsp_pixel_ff <= COLOR_BLUE;
            KIND_BLACK: rsp_pixel_ff <= COLOR_BLACK;
            KIND_RAW:   rsp_pixel_ff <= raw7_ff;
            default:    rsp_pixel_ff <= pixel_in;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

endmodule

// File: dv/letterbox_bilinear_scaler_top_test.sv
// Self-checking testbench for letterbox_bilinear_scaler_top: random source writes and
// destination requests, predicted in-bench and compared on rsp. Depends on lbs_pkg and the RTL.
`timescale 1ns / 1ps

module letterbox_bilinear_scaler_top_test import lbs_pkg::*; ;

   localparam int   LIMIT      = 1000000;
   localparam int   TAIL       = 20;

   typedef enum logic [1:0] {AREA_BLUE, AREA_BLACK, AREA_FIT} area_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_op = 1'b0;
   logic [COORD_BITS-1:0] req_x = '0;
   logic [COORD_BITS-1:0] req_y = '0;
   logic [PIXEL_BITS-1:0] req_pixel_in = '0;
   logic req_raw_copy = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [PIXEL_BITS-1:0] rsp_pixel_out;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   letterbox_bilinear_scaler_top u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the block: raw register values and every stored source pixel.
   logic [SIZE_BITS-1:0] sw_reg = 11'd640, sh_reg = 11'd480;
   logic [DST_BITS-1:0]  dw_reg = 12'd800, dh_reg = 12'd800;
   logic [PIXEL_BITS-1:0] frame_copy [int];

   item_type              pending [$];
   logic [PIXEL_BITS-1:0] pixel_expect [$];
   int issued = 0, accepted = 0, checked = 0, mismatches = 0, cycles = 0;
   int blends = 0, edges = 0, queued = 0;
   bit no_idle = 0, long_stall_arm = 0;

   function automatic int idle_len();
      if (no_idle) return 0;
      if ($urandom_range(0, 24) == 0) return $urandom_range(15, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic longint eff_size(logic [SIZE_BITS-1:0] v, int maxv);
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return v;
   endfunction

   task automatic enqueue_item(input item_type it);
      pending.insert(pending.size(), it);
      queued++;
   endtask

   task automatic expect_pixel(input logic [PIXEL_BITS-1:0] pix);
      pixel_expect.insert(pixel_expect.size(), pix);
   endtask

   task automatic fit_window(output longint x1, x2, y1, y2);
      longint w, h, dw, dh, mx, my;
      w = eff_size(sw_reg, SRC_WIDTH_MAX);
      h = eff_size(sh_reg, SRC_HEIGHT_MAX);
      dw = (dw_reg == 0) ? 1 : dw_reg;
      dh = (dh_reg == 0) ? 1 : dh_reg;
      if (w * dh > dw * h) begin
         mx = 0;
         my = (dh * w - h * dw) / w;
      end else begin
         my = 0;
         mx = (dw * h - w * dh) / h;
      end
      x1 = mx / 2; x2 = dw - mx / 2;
      y1 = my / 2; y2 = dh - my / 2;
   endtask

   task automatic map_axis(input longint off, span, size,
                           output longint idx, w0, w1);
      longint u, d, e;
      u = ((off * size) << FRAC) / span;
      idx = u >> FRAC;
      if (idx > size - 2) idx = size - 2;
      d = u - (idx << FRAC);
      e = d - ONE;
      if (e < 0) e = -e;
      w0 = ONE - d;
      w1 = ONE - e;
   endtask

   task automatic locate(input longint x, y, output area_type area,
                         output longint x0, y0, wx0, wx1, wy0, wy1);
      longint x1, x2, y1, y2;
      fit_window(x1, x2, y1, y2);
      area = AREA_FIT;
      x0 = 0; y0 = 0; wx0 = 0; wx1 = 0; wy0 = 0; wy1 = 0;
      if (x < x1 || x >= x2) area = AREA_BLUE;
      else if (y < y1 || y >= y2) area = AREA_BLACK;
      else begin
         map_axis(x - x1, x2 - x1, eff_size(sw_reg, SRC_WIDTH_MAX), x0, wx0, wx1);
         map_axis(y - y1, y2 - y1, eff_size(sh_reg, SRC_HEIGHT_MAX), y0, wy0, wy1);
      end
   endtask

   function automatic logic [CH_BITS-1:0] blend_channel(logic [PIXEL_BITS-1:0] p [4],
                                                       longint wt [4], int sh);
      longint acc, v;
      acc = 0;
      for (int k = 0; k < 4; k++) acc += wt[k] * longint'((p[k] >> sh) & 8'hFF);
      if (acc <= 0) return 8'd0;
      v = (acc * GAIN_NUM) >>> GAIN_SHIFT;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   task automatic add_write(input int x, y, input logic [PIXEL_BITS-1:0] pix);
      item_type it;
      it.op = OP_WRITE; it.raw = 1'($urandom_range(0, 1));
      it.x = COORD_BITS'(x); it.y = COORD_BITS'(y); it.pix = pix;
      enqueue_item(it);
      if (x < SRC_WIDTH_MAX && y < SRC_HEIGHT_MAX) frame_copy[y * SRC_WIDTH_MAX + x] = pix;
   endtask

   function automatic logic [PIXEL_BITS-1:0] rand_pixel();
      case ($urandom_range(0, 5))
         0: return 24'hFFFFFF;
         1: return 24'h000000;
         default: return PIXEL_BITS'($urandom);
      endcase
   endfunction

   // Queues one request; any neighbor not yet stored is written first.
   task automatic add_request(input int x, y, input bit raw);
      item_type it;
      area_type area;
      longint x0, y0, wx0, wx1, wy0, wy1;
      longint wt [4];
      logic [PIXEL_BITS-1:0] p [4];
      int addr;
      locate(x, y, area, x0, y0, wx0, wx1, wy0, wy1);
      if (area == AREA_FIT) begin
         for (int k = 0; k < 4; k++) begin
            addr = int'((y0 + k / 2) * SRC_WIDTH_MAX + x0 + k % 2);
            if (!frame_copy.exists(addr))
               add_write(int'(x0 + k % 2), int'(y0 + k / 2), rand_pixel());
            p[k] = frame_copy[addr];
         end
      end
      it.op = OP_REQUEST; it.raw = raw; it.x = COORD_BITS'(x); it.y = COORD_BITS'(y);
      it.pix = PIXEL_BITS'($urandom);
      enqueue_item(it);
      case (area)
         AREA_BLUE:  begin expect_pixel(COLOR_BLUE); edges++; end
         AREA_BLACK: begin expect_pixel(COLOR_BLACK); edges++; end
         default: begin
            if (raw) expect_pixel(p[0]);
            else begin
               wt[0] = wy0 * wx0; wt[1] = wy0 * wx1;
               wt[2] = wy1 * wx0; wt[3] = wy1 * wx1;
               expect_pixel({blend_channel(p, wt, 16), blend_channel(p, wt, 8),
                             blend_channel(p, wt, 0)});
               blends++;
            end
         end
      endcase
   endtask

   task automatic drain();
      while (!(pending.size() == 0 && accepted == issued && pixel_expect.size() == 0))
         @(posedge clock);
      repeat (TAIL) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_SRC_WIDTH:  sw_reg = value[SIZE_BITS-1:0];
         REG_SRC_HEIGHT: sh_reg = value[SIZE_BITS-1:0];
         REG_DST_WIDTH:  dw_reg = value[DST_BITS-1:0];
         default:        dh_reg = value[DST_BITS-1:0];
      endcase
   endtask

   // Upper bits are junk on purpose; the block keeps only the register width.
   task automatic configure(input int sw, sh, dw, dh);
      csr_write(REG_SRC_WIDTH,  ($urandom & 32'hFFFF_F800) | sw);
      csr_write(REG_SRC_HEIGHT, ($urandom & 32'hFFFF_F800) | sh);
      csr_write(REG_DST_WIDTH,  ($urandom & 32'hFFFF_F000) | dw);
      csr_write(REG_DST_HEIGHT, ($urandom & 32'hFFFF_F000) | dh);
   endtask

   // Queues about count transactions, neighbor writes included.
   task automatic random_items(input int count);
      longint x1, x2, y1, y2;
      int pick, target;
      fit_window(x1, x2, y1, y2);
      target = queued + count;
      while (queued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            add_request($urandom_range(int'(x1), int'(x2 - 1)),
                        $urandom_range(int'(y1), int'(y2 - 1)),
                        $urandom_range(0, 4) == 0);
         else if (pick < 80)
            add_request($urandom_range(0, 4095), $urandom_range(0, 4095),
                        1'($urandom_range(0, 1)));
         else if (pick < 93)
            add_write($urandom_range(0, int'(eff_size(sw_reg, SRC_WIDTH_MAX) - 1)),
                      $urandom_range(0, int'(eff_size(sh_reg, SRC_HEIGHT_MAX) - 1)),
                      rand_pixel());
         else
            add_write($urandom_range(0, 4095), $urandom_range(0, 4095), rand_pixel());
      end
   endtask

   always @(posedge clock) begin
      item_type it;
      int send_gap;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) accepted++;
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending.size() > 0) begin
               it = pending.pop_front();
               req_op <= it.op; req_x <= it.x; req_y <= it.y;
               req_pixel_in <= it.pix; req_raw_copy <= it.raw;
               req_valid <= 1'b1;
               issued++;
               send_gap = idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver side: random stalls plus one long hold-off to back the pipeline up.
   always @(posedge clock) begin
      int hold, stall_left;
      bit long_done;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold = 0; stall_left = 0; long_done = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (long_stall_arm && !long_done && rsp_valid) begin
         long_done = 1;
         stall_left = 600;
         rsp_ready <= 1'b0;
      end else if (hold > 0) begin
         hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         hold = idle_len();
      end
   end

   always @(posedge clock) begin
      logic [PIXEL_BITS-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp transaction, pixel_out=%06h",
                                           rsp_pixel_out);
         end else begin
            want = pixel_expect.pop_front();
            checked++;
            if (rsp_pixel_out !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("pixel_out mismatch #%0d: expected %06h, got %06h",
                                              checked, want, rsp_pixel_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", LIMIT);
         $display("[letterbox_bilinear_scaler_top] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset geometry: 640x480 into 800x800, rows 100..699 fitted.
      add_write(0, 0, 24'hFFFFFF); add_write(1, 0, 24'hFFFFFF);
      add_write(0, 1, 24'hFFFFFF); add_write(1, 1, 24'hFFFFFF);
      add_request(0, 100, 0);
      add_request(0, 100, 1);
      add_request(0, 0, 0);
      add_request(0, 99, 1);
      add_request(0, 700, 0);
      add_request(800, 100, 0);
      add_request(4095, 4095, 1);
      add_request(799, 699, 0);
      add_request(799, 699, 1);
      add_write(4095, 4095, 24'hABCDEF);
      add_write(1024, 3, 24'h123456);
      add_write(639, 479, 24'h000000);
      add_write(638, 479, 24'hFFFFFF);
      add_request(799, 699, 0);
      add_request(400, 400, 0);
      add_request(2048, 2048, 1);
      drain();

      for (int phase = 1; phase <= 13; phase++) begin
         no_idle = (phase % 4 == 0);
         case (phase)
            1: configure(0, 1, 0, 4095);
            2: configure(1024, 1024, 4095, 4095);
            3: configure(2047, 2, 4095, 1);
            4: configure(2, 1024, 1, 4095);
            default:
               if ($urandom_range(0, 3) == 0)
                  configure($urandom_range(0, 2047), $urandom_range(0, 2047),
                            $urandom_range(0, 4095), $urandom_range(0, 4095));
               else
                  configure($urandom_range(2, 12), $urandom_range(2, 12),
                            $urandom_range(1, 64), $urandom_range(1, 64));
         endcase
         if (phase == 2) begin
            no_idle = 1;
            long_stall_arm = 1;
         end
         random_items(150);
         drain();
      end

      $display("checked %0d results (%0d blended, %0d letterbox fill) over 14 register settings",
               checked, blends, edges);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && pixel_expect.size() == 0)
         $display("[letterbox_bilinear_scaler_top] OK");
      else
         $display("[letterbox_bilinear_scaler_top] ERROR");
      $finish;
   end

endmodule
